// ----- design/hi3_pkg.sv -----
// Shared types, widths and curve tables for the 3D Hilbert index unit.
package hi3_pkg;

  // Fixed widths of the coordinate and index fields.
  localparam int unsigned COORD_W = 21;
  localparam int unsigned INDEX_W = 63;

  typedef logic [2:0] hi3_digit_t;

  // Rotation: one digit for each of the eight octants.
  typedef hi3_digit_t [7:0] hi3_rot_t;

  // Payload handed from one cell to the next.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    hi3_rot_t           rot;
    logic [INDEX_W-1:0] code;
  } hi3_data_t;

  // Octant-to-digit map at the start of every point (entry 0 is the low digit).
  localparam hi3_rot_t BASE_MAP = {3'd5, 3'd6, 3'd2, 3'd1, 3'd4, 3'd7, 3'd3, 3'd0};

  // Rotation update: every entry holding the value r becomes NEXT_ROT[digit][r].
  localparam hi3_digit_t NEXT_ROT [8][8] = '{
    '{3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5, 3'd4, 3'd3},
    '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1},
    '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1},
    '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
    '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
    '{3'd6, 3'd5, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd7},
    '{3'd6, 3'd5, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd7},
    '{3'd4, 3'd3, 3'd2, 3'd5, 3'd6, 3'd1, 3'd0, 3'd7}
  };

endpackage

// ----- design/hilbert_index_3d_unit.sv -----
// Top level of the 3D Hilbert curve index unit: a chain of one cell per level.
//
// Usage: present a point on coord_x_i, coord_y_i and coord_z_i together with
// start_i. A beat is taken at every rising edge with start_i high and busy_o
// low; busy_o is always low, so a new point may be given in every cycle.
// Coordinates are unsigned integers already scaled to LEVELS bits; bits at
// positions LEVELS and above are ignored.
// Each point walks a row of LEVELS cells, one per level from the top bit
// down. Every cell registers its result, so the index of a point appears on
// curve_index_o once it has passed the register of every cell, marked by a
// one-cycle done_o strobe, and points leave in the order they entered.
// Throughput is one point per cycle.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset clears every beat marker in the chain, so points in flight are
// dropped and no strobe follows until a new point is taken.
module hilbert_index_3d_unit import hi3_pkg::*; #(
  parameter int unsigned LEVELS = 21
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [COORD_W-1:0] coord_z_i,
  output logic               done_o,
  output logic [INDEX_W-1:0] curve_index_o
);

  logic      valid [LEVELS+1];
  hi3_data_t data  [LEVELS+1];

  // The chain never holds a point back.
  assign busy_o = 1'b0;

  // Head of the chain: fresh rotation and an empty index.
  assign valid[0]     = start_i & ~busy_o;
  assign data[0].x    = coord_x_i;
  assign data[0].y    = coord_y_i;
  assign data[0].z    = coord_z_i;
  assign data[0].rot  = BASE_MAP;
  assign data[0].code = '0;

  // One cell per level, top coordinate bit first.
  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    hi3_cell #(
      .BIT_POS(LEVELS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid[i]),
      .data_i (data[i]),
      .valid_o(valid[i+1]),
      .data_o (data[i+1])
    );
  end

  assign done_o        = valid[LEVELS];
  assign curve_index_o = data[LEVELS].code;

`ifndef SYNTHESIS
  // Every accepted point is followed by a done_o strobe at the end of the chain.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LEVELS done_o)
    else $error("result strobe missing after an accepted point");

  // The zero point maps to the zero index.
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && coord_x_i == '0 && coord_y_i == '0 && coord_z_i == '0)
    |-> ##LEVELS (curve_index_o == '0))
    else $error("zero point gave a non-zero index");

  // Only the low 3*LEVELS index bits can be set.
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((curve_index_o >> (3 * LEVELS)) == '0))
    else $error("index has bits above the level count");
`endif

endmodule

// ----- design/hi3_cell.sv -----
// One level of the Hilbert index chain: emits one digit and updates the rotation.
module hi3_cell import hi3_pkg::*; #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  hi3_data_t data_i,
  output logic      valid_o,
  output hi3_data_t data_o
);

  logic       valid_q;
  hi3_data_t  data_d;
  hi3_data_t  data_q;
  logic [2:0] octant;
  hi3_digit_t digit;

  // Form the octant from this level's coordinate bits and map it to a digit.
  always_comb begin
    octant = {data_i.z[BIT_POS], data_i.y[BIT_POS], data_i.x[BIT_POS]};
    digit  = data_i.rot[octant];
    data_d = data_i;
    for (int k = 0; k < 8; k++) begin
      data_d.rot[k] = NEXT_ROT[digit][data_i.rot[k]];
    end
    data_d.code = {data_i.code[INDEX_W-4:0], digit};
  end

  // Beat marker; cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload moves on every cycle; it needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- tb/tb_hilbert_index_3d_unit.sv -----
// Self-checking testbench for the 3D Hilbert curve index unit.
`timescale 1ns / 100ps

module tb_hilbert_index_3d_unit;
  import hi3_pkg::*;

  localparam int unsigned LEVELS   = 21;
  localparam int unsigned PHASES   = 4;
  localparam int unsigned PER_PHASE = 200;

  // Scoreboard: predicts the curve index of every accepted point and checks results in order.
  class hilbert_scoreboard;
    logic [INDEX_W-1:0] index_q[$];
    int unsigned        mismatches;
    int unsigned        checked;
    bit [2:0]           first_map[8];
    bit [2:0]           turn[8][8];

    function new();
      first_map = '{3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5};
      turn = '{
        '{3'd0, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5, 3'd4, 3'd3},
        '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1},
        '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1},
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5},
        '{3'd6, 3'd5, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd7},
        '{3'd6, 3'd5, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd7},
        '{3'd4, 3'd3, 3'd2, 3'd5, 3'd6, 3'd1, 3'd0, 3'd7}
      };
      mismatches = 0;
      checked    = 0;
    endfunction

    // Walks the levels from the top bit down, one octant digit per level.
    function logic [INDEX_W-1:0] hilbert_index_of(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y,
                                                  logic [COORD_W-1:0] z);
      bit [2:0]           orient[8];
      bit [2:0]           octant;
      bit [2:0]           digit;
      logic [INDEX_W-1:0] code;
      code   = '0;
      orient = first_map;
      for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
        octant = {z[lvl], y[lvl], x[lvl]};
        digit  = orient[octant];
        code   = {code[INDEX_W-4:0], digit};
        for (int k = 0; k < 8; k++) begin
          orient[k] = turn[digit][orient[k]];
        end
      end
      return code;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 50) begin
        $display("[%0t] MISMATCH: %s", $realtime, what);
      end
    endfunction

    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
      index_q.push_back(hilbert_index_of(x, y, z));
    endfunction

    function void check_index(logic [INDEX_W-1:0] got);
      logic [INDEX_W-1:0] want;
      if (index_q.size() == 0) begin
        report($sformatf("curve index %h arrived with no point pending", got));
      end else begin
        want = index_q.pop_front();
        checked++;
        if (got !== want) begin
          report($sformatf("curve index %h, expected %h", got, want));
        end
      end
    endfunction

    function int unsigned pending();
      return index_q.size();
    endfunction
  endclass

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start_i   = 1'b0;
  logic [COORD_W-1:0] coord_x_i = '0;
  logic [COORD_W-1:0] coord_y_i = '0;
  logic [COORD_W-1:0] coord_z_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [INDEX_W-1:0] curve_index_o;

  hilbert_scoreboard sb = new();

  hilbert_index_3d_unit #(
    .LEVELS(LEVELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .done_o       (done_o),
    .curve_index_o(curve_index_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watch both sides of the block at every rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_index(curve_index_o);
      end
      if (start_i && !busy_o) begin
        sb.note_point(coord_x_i, coord_y_i, coord_z_i);
      end
    end
  end

  // Present one point, idling beforehand at the given rate, and hold it until the beat is taken.
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  // One coordinate drawn from a mix of shapes: full range, small, corners, single bits,
  // near neighbours of the previous value and single holes.
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned shape,
                                                    logic [COORD_W-1:0] prev);
    logic [COORD_W-1:0] all_ones;
    all_ones = '1;
    case (shape)
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(15, 0));
      2: begin
        case ($urandom_range(2, 0))
          0:       return '0;
          1:       return all_ones;
          default: return COORD_W'($urandom);
        endcase
      end
      3: return COORD_W'(1) << $urandom_range(COORD_W - 1, 0);
      4: return prev ^ COORD_W'($urandom_range(7, 0));
      default: return ~(COORD_W'(1) << $urandom_range(COORD_W - 1, 0));
    endcase
  endfunction

  // Stimulus: reset, directed corners, then random points under several sender idle rates.
  initial begin
    logic [COORD_W-1:0] px, py, pz;
    logic [COORD_W-1:0] top_bit;
    logic [COORD_W-1:0] all_ones;
    int unsigned        idle_rate[PHASES];
    int unsigned        shape;
    int unsigned        n;

    idle_rate = '{0, 80, 34, 0};
    top_bit   = COORD_W'(1) << (COORD_W - 1);
    all_ones  = '1;
    px = '0;
    py = '0;
    pz = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero point, the all-ones corner, each axis alone at its maximum and two pairs of axes at their maximum.
    send_point('0, '0, '0, 0);
    send_point(all_ones, all_ones, all_ones, 0);
    send_point(all_ones, '0, '0, 0);
    send_point('0, all_ones, '0, 0);
    send_point('0, '0, all_ones, 0);
    send_point(all_ones, all_ones, '0, 0);
    send_point('0, all_ones, all_ones, 0);
    // Every non-zero octant at the top level and at the bottom level.
    for (int oct = 1; oct < 8; oct++) begin
      send_point(oct[0] ? top_bit : '0, oct[1] ? top_bit : '0, oct[2] ? top_bit : '0, 0);
      send_point(COORD_W'(oct[0]), COORD_W'(oct[1]), COORD_W'(oct[2]), 0);
    end
    // Alternating bit patterns swap the octant at every level.
    send_point(21'h155555, 21'h0AAAAA, 21'h155555, 0);
    send_point(21'h0AAAAA, 21'h155555, 21'h0AAAAA, 0);
    send_point(21'h155555, 21'h155555, 21'h0AAAAA, 0);

    // Random points, one phase per sender idle rate.
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < PER_PHASE; i++) begin
        shape = $urandom_range(6, 0);
        if (shape == 6) begin
          // All three axes equal: the main diagonal of the cube.
          px = pick_coord($urandom_range(5, 0), px);
          py = px;
          pz = px;
        end else begin
          px = pick_coord(shape, px);
          py = pick_coord($urandom_range(1, 0) ? shape : $urandom_range(5, 0), py);
          pz = pick_coord($urandom_range(1, 0) ? shape : $urandom_range(5, 0), pz);
        end
        send_point(px, py, pz, idle_rate[ph]);
      end
    end
    start_i <= 1'b0;

    // Drain the chain, then wait on for any stray strobe.
    n = 0;
    while (sb.pending() != 0 && n < 2000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (LEVELS + 4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d curve indices never arrived", sb.pending()));
    end

    $display("Checked %0d curve indices: zero point, cube corners, every octant at top and",
             sb.checked);
    $display("bottom level, then random points with sender idle rates of 0, 80 and 34 percent.");
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #2000000;
    $display("Timed out with %0d curve indices outstanding.", sb.pending());
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
design/hi3_pkg.sv
design/hi3_cell.sv
design/hilbert_index_3d_unit.sv
tb/tb_hilbert_index_3d_unit.sv
